// File: hdl/sdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types and constants for the stereo direct convolution block.
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam int DEF_MAX_TAPS    = 4096;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int OUT_W       = 48;
    localparam int TAP_COUNT_W = 13;
    localparam int TAP_INDEX_W = 12;
    localparam int REQ_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_TAP = 2'd0,
        REQ_FRAME    = 2'd1,
        REQ_RESTART  = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_COUNT       = 2'd0,
        CFG_SIGNAL_STEREO   = 2'd1,
        CFG_RESPONSE_STEREO = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic tap_wr;   // store one tap pair
        logic start;    // store frame, set up loop, clear sums
        logic restart;  // clear history age and write position
        logic issue;    // read one tap and one history entry
        logic finish;   // move sums into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic n_zero;     // no taps to sum for this frame
        logic last;       // current read is the final tap
        logic pipe_busy;  // reads or products still in flight
        logic out_free;   // output register can take a result
    } t_status;

endpackage : sdc_pkg
`default_nettype wire

// File: hdl/stereo_direct_convolution_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_direct_convolution_top
// Direct-form stereo FIR convolution of a sample stream with a loaded
// impulse response.
// ----------------------------------------------------------------------------
// Items on the input channel are tap loads (req_type 0), signal frames
// (req_type 1) or history restarts (req_type 2); code 3 is dropped. A tap
// load or a restart gives no result. A signal frame is written into the
// circular history and then the block sums sample[n-k] * tap[k] over
// n = min(tap_count, MAX_TAPS, frames since the last restart) taps, one
// tap per cycle per channel: the single read port of each tap/history
// memory sets that pace. A frame goes through accept, the tap reads, the
// pipeline drain and the hand-off, with no reads when no taps are in use;
// it stays in the drain step while the previous result has not yet been taken.
// One result item with two 48-bit Q.30 sums comes back per frame; the
// right sum is zero when both signal and response are mono. The output
// register lets a new item be accepted while the last result still waits.
// Config registers (0 tap_count, 1 signal_stereo, 2 response_stereo) are
// written through the plain write port; the user must write them only
// while the block is idle, which the block itself does not enforce. Taps
// and history entries that were never written read back as undefined.
// ----------------------------------------------------------------------------
module stereo_direct_convolution_top
    import sdc_pkg::*;
#(
    parameter int MAX_TAPS    = DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input item channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [REQ_W-1:0]              i_req_type,
    input  wire logic [TAP_INDEX_W-1:0]        i_tap_index,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_value,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_value,
    // result item channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [OUT_W-1:0]            o_out_left,
    output logic signed [OUT_W-1:0]            o_out_right,
    // config write port
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // sequencer: owns the item handshake and the frame loop
    sdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // memories, MAC pipeline and output register
    sdc_datapath #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_tap_index   (i_tap_index),
        .i_left_value  (i_left_value),
        .i_right_value (i_right_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_left    (o_out_left),
        .o_out_right   (o_out_right)
    );

    // an accepted frame always takes the block busy in the next cycle
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_req_type == REQ_FRAME) |=> !o_in_ready)
        else $error("frame accepted but block did not go busy");

    // no tap reads while the input side is open
    a_issue_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> !o_in_ready)
        else $error("tap read issued while accepting items");

    // a result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten");

    // hand-off only after the MAC pipeline has emptied, and it shows up
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!status.pipe_busy ##1 o_out_valid))
        else $error("result handed off with products in flight");

endmodule : stereo_direct_convolution_top
`default_nettype wire

// File: hdl/sdc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : sdc_ram
`default_nettype wire

// File: hdl/sdc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_datapath
// Tap and history memories, config registers, MAC pipeline, output register.
// ----------------------------------------------------------------------------
module sdc_datapath
    import sdc_pkg::*;
#(
    parameter int MAX_TAPS    = DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cmd                          i_cmd,
    output t_status                            o_status,
    input  wire logic [TAP_INDEX_W-1:0]        i_tap_index,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_value,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_value,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [OUT_W-1:0]            o_out_left,
    output logic signed [OUT_W-1:0]            o_out_right
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int MW = (CW > TAP_COUNT_W) ? CW : TAP_COUNT_W;
    localparam int SB = SAMPLE_BITS;
    localparam int PW = 2 * SAMPLE_BITS;

    // config
    logic [TAP_COUNT_W-1:0] r_tap_count;
    logic                   r_sig_st;
    logic                   r_resp_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_W'(1);
            r_sig_st    <= 1'b0;
            r_resp_st   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TAP_COUNT:       r_tap_count <= i_cfg_data[TAP_COUNT_W-1:0];
                CFG_SIGNAL_STEREO:   r_sig_st    <= i_cfg_data[0];
                CFG_RESPONSE_STEREO: r_resp_st   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // history bookkeeping and loop counters
    logic [AW-1:0] r_wpos, r_hptr, r_k;
    logic [CW-1:0] r_frames, r_n;
    logic [CW-1:0] frames_inc;
    logic [MW-1:0] tc_ext, tc_lim, n_full;
    logic          tap_in_range;

    always_comb begin
        frames_inc = (r_frames < CW'(MAX_TAPS)) ? r_frames + CW'(1) : r_frames;
        tc_ext     = MW'(r_tap_count);
        tc_lim     = (tc_ext > MW'(MAX_TAPS)) ? MW'(MAX_TAPS) : tc_ext;
        n_full     = (tc_lim < MW'(frames_inc)) ? tc_lim : MW'(frames_inc);
        tap_in_range = 32'(i_tap_index) < 32'(MAX_TAPS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos   <= '0;
            r_frames <= '0;
        end else if (i_cmd.restart) begin
            r_wpos   <= '0;
            r_frames <= '0;
        end else if (i_cmd.start) begin
            r_wpos   <= (r_wpos == AW'(MAX_TAPS - 1)) ? '0 : r_wpos + AW'(1);
            r_frames <= frames_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n    <= CW'(n_full);
            r_k    <= '0;
            r_hptr <= r_wpos;
        end else if (i_cmd.issue) begin
            r_k    <= r_k + AW'(1);
            r_hptr <= (r_hptr == '0) ? AW'(MAX_TAPS - 1) : r_hptr - AW'(1);
        end
    end

    // memories: {right, left}
    logic [PW-1:0] tap_rd, hist_rd;

    sdc_ram #(.WIDTH(PW), .DEPTH(MAX_TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tap_wr && tap_in_range),
        .i_waddr (AW'(i_tap_index)),
        .i_wdata ({i_right_value, i_left_value}),
        .i_raddr (r_k),
        .o_rdata (tap_rd)
    );

    sdc_ram #(.WIDTH(PW), .DEPTH(MAX_TAPS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.start),
        .i_waddr (r_wpos),
        .i_wdata ({i_right_value, i_left_value}),
        .i_raddr (r_hptr),
        .o_rdata (hist_rd)
    );

    // MAC pipeline: read -> product -> accumulate
    logic                 r_v1, r_v2;
    logic signed [SB-1:0] sl, sr, tl, tr;
    logic signed [PW-1:0] r_pl, r_pr;
    logic signed [OUT_W-1:0] r_acc_l, r_acc_r;

    always_comb begin
        sl = signed'(hist_rd[SB-1:0]);
        sr = r_sig_st  ? signed'(hist_rd[PW-1:SB]) : sl;
        tl = signed'(tap_rd[SB-1:0]);
        tr = r_resp_st ? signed'(tap_rd[PW-1:SB])  : tl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl <= sl * tl;
        r_pr <= sr * tr;
        if (i_cmd.start) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_v2) begin
            r_acc_l <= r_acc_l + OUT_W'(r_pl);
            r_acc_r <= r_acc_r + OUT_W'(r_pr);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out_left  <= r_acc_l;
            o_out_right <= (r_sig_st || r_resp_st) ? r_acc_r : '0;
        end
    end

    always_comb begin
        o_status.n_zero    = (r_n == '0);
        o_status.last      = ((CW'(r_k) + CW'(1)) == r_n);
        o_status.pipe_busy = r_v1 || r_v2;
        o_status.out_free  = !o_out_valid || i_out_ready;
    end

endmodule : sdc_datapath
`default_nettype wire

// File: hdl/sdc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_ctrl
// Sequencer: accepts items, steps the tap loop, drains, hands off the result.
// ----------------------------------------------------------------------------
module sdc_ctrl
    import sdc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [REQ_W-1:0] i_req_type,
    input  wire t_status          i_status,
    output t_cmd                  o_cmd
);

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_req_type == REQ_FRAME) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.n_zero || i_status.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy && i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                unique case (i_req_type)
                    REQ_LOAD_TAP: o_cmd.tap_wr  = accept;
                    REQ_FRAME:    o_cmd.start   = accept;
                    REQ_RESTART:  o_cmd.restart = accept;
                    default: ;
                endcase
            end
            ST_RUN: begin
                o_cmd.issue = !i_status.n_zero;
            end
            ST_DRAIN: begin
                o_cmd.finish = !i_status.pipe_busy && i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule : sdc_ctrl
`default_nettype wire

// File: sim/stereo_direct_convolution_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_direct_convolution_top_tb
// Self-checking bench for the stereo direct-form convolution block.
// ----------------------------------------------------------------------------
// Tap loads, signal frames, restarts and unused request codes are sent
// through the valid/ready input channel. A predictor in this file keeps
// its own tap memory, circular history and register copies, and computes
// the exact Q.30 sums of every accepted frame. Each result item is checked
// field by field against the oldest pending frame. Directed tests cover
// value extremes, all four channel modes, tap count zero and oversized
// counts, and the unused code. Random phases then mix frames, loads and
// restarts under several register settings, and a long frame run goes
// back to back. Both sides stall at random, except during that burst.
// ----------------------------------------------------------------------------
module stereo_direct_convolution_top_tb;
    import sdc_pkg::*;

    localparam int MAX_TAPS    = DEF_MAX_TAPS;
    localparam int SB          = DEF_SAMPLE_BITS;
    localparam int STALL_LIMIT = 2000;   // far above the slowest frame here
    localparam int DRAIN_WAIT  = 16;

    localparam logic [REQ_W-1:0]    REQ_UNUSED = 2'd3;
    localparam logic signed [SB-1:0] V_MIN     = 16'sh8000;
    localparam logic signed [SB-1:0] V_MAX     = 16'sh7FFF;

    typedef struct {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
    } t_sums;

    // DUT ports; every input has a known value from time zero
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_ready;
    logic [REQ_W-1:0]        i_req_type    = '0;
    logic [TAP_INDEX_W-1:0]  i_tap_index   = '0;
    logic signed [SB-1:0]    i_left_value  = '0;
    logic signed [SB-1:0]    i_right_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready   = 1'b0;
    logic signed [OUT_W-1:0] o_out_left;
    logic signed [OUT_W-1:0] o_out_right;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    // predictor state
    logic signed [SB-1:0]   coef_l [MAX_TAPS];
    logic signed [SB-1:0]   coef_r [MAX_TAPS];
    logic signed [SB-1:0]   hist_l [MAX_TAPS];
    logic signed [SB-1:0]   hist_r [MAX_TAPS];
    logic [TAP_INDEX_W-1:0] hist_pos   = '0;
    int                     hist_age   = 0;
    logic [TAP_COUNT_W-1:0] taps_used  = 13'd1;
    logic                   sig_stereo = 1'b0;
    logic                   rsp_stereo = 1'b0;

    t_sums expected_sums[$];

    int  error_count  = 0;
    int  items_sent   = 0;
    int  frames_done  = 0;
    int  settings_cnt = 0;
    int  stall_cycles = 0;
    bit  no_idle      = 1'b0;

    stereo_direct_convolution_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_tap_index  (i_tap_index),
        .i_left_value (i_left_value),
        .i_right_value(i_right_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_left   (o_out_left),
        .o_out_right  (o_out_right),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Update the predictor with one accepted item; frames queue their sums.
    task automatic convolve_item(input logic [REQ_W-1:0] kind,
                                 input logic [TAP_INDEX_W-1:0] idx,
                                 input logic signed [SB-1:0] lv,
                                 input logic signed [SB-1:0] rv);
        t_sums                  s;
        int                     n;
        logic [TAP_INDEX_W-1:0] h;
        longint                 acc_l, acc_r, sl, sr, tl, tr;
        case (kind)
            REQ_LOAD_TAP: begin
                coef_l[idx] = lv;
                coef_r[idx] = rv;
            end
            REQ_RESTART: begin
                hist_age = 0;
                hist_pos = '0;
            end
            REQ_FRAME: begin
                hist_l[hist_pos] = lv;
                hist_r[hist_pos] = rv;
                if (hist_age < MAX_TAPS) hist_age++;
                n = int'(taps_used);
                if (n > MAX_TAPS) n = MAX_TAPS;
                if (n > hist_age) n = hist_age;
                acc_l = 0;
                acc_r = 0;
                for (int k = 0; k < n; k++) begin
                    h  = hist_pos - TAP_INDEX_W'(k);
                    sl = hist_l[h];
                    sr = sig_stereo ? longint'(hist_r[h]) : sl;
                    tl = coef_l[k];
                    tr = rsp_stereo ? longint'(coef_r[k]) : tl;
                    acc_l += sl * tl;
                    acc_r += sr * tr;
                end
                if (!sig_stereo && !rsp_stereo) acc_r = 0;
                s.left  = acc_l[OUT_W-1:0];
                s.right = acc_r[OUT_W-1:0];
                expected_sums.push_back(s);
                hist_pos = hist_pos + TAP_INDEX_W'(1);
            end
            default: ;  // unused code: dropped by the block
        endcase
    endtask

    // Called at a rising edge; returns at the edge that accepts the item.
    // Valid is left high so a following item needs no extra edge.
    task automatic send_item(input logic [REQ_W-1:0] kind,
                             input logic [TAP_INDEX_W-1:0] idx,
                             input logic signed [SB-1:0] lv,
                             input logic signed [SB-1:0] rv);
        while (!no_idle && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= kind;
        i_tap_index   <= idx;
        i_left_value  <= lv;
        i_right_value <= rv;
        do @(posedge i_clk); while (!o_in_ready);
        convolve_item(kind, idx, lv, rv);
        items_sent++;
    endtask

    // Drop valid, wait for all pending frames, then let the block go idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges; block must be idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] count,
                              input logic ss, input logic rs);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TAP_COUNT;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SIGNAL_STEREO;
        i_cfg_data <= CFG_DATA_W'(ss);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RESPONSE_STEREO;
        i_cfg_data <= CFG_DATA_W'(rs);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        taps_used  = count;
        sig_stereo = ss;
        rsp_stereo = rs;
        settings_cnt++;
    endtask

    function automatic logic signed [SB-1:0] pick_value();
        case ($urandom_range(9))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return '0;
            default: return SB'($urandom);
        endcase
    endfunction

    // reset defaults: one tap, mono signal, mono response
    task automatic test_mono_mono();
        send_item(REQ_LOAD_TAP, 12'd0, V_MAX, 16'sh1234);
        send_item(REQ_FRAME, 12'd0, V_MIN, V_MAX);   // right must read zero
        send_item(REQ_FRAME, 12'd0, V_MAX, V_MIN);
        settle();
        set_config(13'd4, 1'b0, 1'b0);
        send_item(REQ_LOAD_TAP, 12'd1, V_MIN, V_MIN);
        send_item(REQ_LOAD_TAP, 12'd2, V_MAX, V_MIN);
        send_item(REQ_LOAD_TAP, 12'd3, -16'sd1, 16'sd1);
        send_item(REQ_FRAME, 12'd0, V_MIN, V_MIN);   // min*min = +2^30
        send_item(REQ_FRAME, 12'd0, V_MIN, 16'sd7);
    endtask

    // the three modes with at least one stereo side
    task automatic test_channel_modes();
        for (int m = 1; m < 4; m++) begin
            settle();
            set_config(13'd4, m[0], m[1]);
            send_item(REQ_RESTART, 12'd0, '0, '0);
            send_item(REQ_FRAME, 12'd0, 16'sd1000, -16'sd3000);
            send_item(REQ_FRAME, 12'd0, V_MAX, V_MIN);
        end
    endtask

    // unused code, zero taps in use, load at the top tap index
    task automatic test_special_items();
        settle();
        set_config(13'd0, 1'b1, 1'b1);
        send_item(REQ_UNUSED, 12'hFFF, V_MIN, V_MAX);
        send_item(REQ_FRAME, 12'd0, V_MAX, V_MAX);
        send_item(REQ_LOAD_TAP, 12'hFFF, V_MIN, V_MAX);
    endtask

    // counts past the tap memory clamp to its size; history age limits n
    task automatic test_tap_count_limits();
        settle();
        set_config(13'd4097, 1'b1, 1'b1);
        send_item(REQ_RESTART, 12'd0, '0, '0);
        for (int i = 0; i < 3; i++)
            send_item(REQ_FRAME, 12'd0, pick_value(), pick_value());
        settle();
        set_config(13'h1FFF, 1'b0, 1'b1);
        send_item(REQ_FRAME, 12'd0, V_MIN, V_MAX);
    endtask

    // Each phase reloads every tap in use, so no unwritten tap is read.
    task automatic test_random_phases();
        int                     count;
        int                     roll;
        logic [TAP_INDEX_W-1:0] idx;
        for (int p = 0; p < 6; p++) begin
            settle();
            count = (p == 0) ? 1 : (p == 5) ? 16 : $urandom_range(2, 8);
            set_config(CFG_DATA_W'(count), p[0], p[1]);
            if ($urandom_range(1)) send_item(REQ_RESTART, 12'($urandom), '0, '0);
            for (int k = 0; k < count; k++)
                send_item(REQ_LOAD_TAP, 12'(k), pick_value(), pick_value());
            for (int i = 0; i < 6; i++) begin
                roll = $urandom_range(99);
                idx  = 12'($urandom);
                if (roll < 72)
                    send_item(REQ_FRAME, idx, pick_value(), pick_value());
                else if (roll < 84)
                    send_item(REQ_LOAD_TAP, idx, pick_value(), pick_value());
                else if (roll < 92)
                    send_item(REQ_RESTART, idx, pick_value(), pick_value());
                else
                    send_item(REQ_UNUSED, idx, pick_value(), pick_value());
            end
        end
    endtask

    // Long run of frames with no stalls on either side.
    task automatic test_burst();
        settle();
        set_config(13'd5, 1'b1, 1'b0);
        for (int k = 0; k < 5; k++)
            send_item(REQ_LOAD_TAP, 12'(k), pick_value(), pick_value());
        send_item(REQ_RESTART, 12'd0, '0, '0);
        no_idle = 1'b1;
        for (int i = 0; i < 32; i++)
            send_item(REQ_FRAME, 12'($urandom), pick_value(), pick_value());
        no_idle = 1'b0;
    endtask

    // result side: random back-pressure
    always @(posedge i_clk)
        i_out_ready <= no_idle || ($urandom_range(99) >= 24);

    always @(posedge i_clk) begin : check_results
        t_sums want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch("result item with no frame pending");
            end else begin
                want = expected_sums.pop_front();
                if (o_out_left !== want.left)
                    report_mismatch($sformatf("frame %0d out_left %0d, want %0d",
                                              frames_done, o_out_left, want.left));
                if (o_out_right !== want.right)
                    report_mismatch($sformatf("frame %0d out_right %0d, want %0d",
                                              frames_done, o_out_right, want.right));
            end
            frames_done++;
        end
    end

    // Watchdog: no handshake and no register write for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved in %0d cycles", STALL_LIMIT);
            $display("stereo_direct_convolution_top_tb: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_mono_mono();
        test_channel_modes();
        test_special_items();
        test_tap_count_limits();
        test_random_phases();
        test_burst();
        settle();
        $display("covered %0d items and %0d frame results over %0d register settings",
                 items_sent, frames_done, settings_cnt);
        $display("modes mono/stereo both sides, tap counts 0 to 8191, unstalled burst");
        if (error_count == 0) begin
            $display("stereo_direct_convolution_top_tb: clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("stereo_direct_convolution_top_tb: errors");
        end
        $finish;
    end

endmodule : stereo_direct_convolution_top_tb
`default_nettype wire
